### rtl/mtok_pkg.sv
// ----------------------------------------------------------------------------
// Markup tokenizer package
// Shared types, result codes and the lexer transition function.
// ----------------------------------------------------------------------------
package mtok_pkg;

	// Lexer states. The emit state is only ever a transition target; the
	// lexer falls back to text in the same cycle.
	typedef enum logic [3:0] {
		ST_TEXT       = 4'd0,
		ST_LT         = 4'd1,
		ST_TAG        = 4'd2,
		ST_SLASH      = 4'd3,
		ST_EMIT       = 4'd4,
		ST_BANG       = 4'd5,
		ST_DASH1      = 4'd6,
		ST_DASH2      = 4'd7,
		ST_BANG_DASH  = 4'd8,
		ST_COMMENT    = 4'd9,
		ST_NAME       = 4'd10
	} lex_state_t;

	// Result kinds on the token channel.
	localparam logic [2:0] KIND_TEXT_BYTE    = 3'd0;
	localparam logic [2:0] KIND_TAG_BYTE     = 3'd1;
	localparam logic [2:0] KIND_COMMENT_BYTE = 3'd2;
	localparam logic [2:0] KIND_TEXT_END     = 3'd3;
	localparam logic [2:0] KIND_OPEN_END     = 3'd4;
	localparam logic [2:0] KIND_CLOSE_END    = 3'd5;
	localparam logic [2:0] KIND_COMMENT_END  = 3'd6;

	// Characters the lexer reacts to.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// One input byte causes at most one byte word and three end words.
	localparam int MAX_RES   = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       blank;
		logic       last;
	} tok_res_t;

	function automatic logic is_blank_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	// Transition table of the lexer, folded with its byte classes.
	function automatic lex_state_t next_lex(input lex_state_t s, input logic [7:0] c);
		lex_state_t ns;
		unique case (s)
			ST_TEXT:      ns = (c == CH_LT) ? ST_LT : ST_TEXT;
			ST_LT: begin
				if (c == CH_BANG)
					ns = ST_BANG;
				else if (c == CH_SLASH)
					ns = ST_SLASH;
				else
					ns = ST_NAME;
			end
			ST_TAG:       ns = (c == CH_GT) ? ST_EMIT : ST_TAG;
			ST_SLASH:     ns = ST_TAG;
			ST_BANG:      ns = (c == CH_DASH) ? ST_BANG_DASH : ST_TAG;
			ST_DASH1:     ns = (c == CH_DASH) ? ST_DASH2 : ST_COMMENT;
			ST_DASH2:     ns = (c == CH_GT) ? ST_EMIT : ST_COMMENT;
			ST_BANG_DASH: ns = (c == CH_DASH) ? ST_COMMENT : ST_TAG;
			ST_COMMENT:   ns = (c == CH_DASH) ? ST_DASH1 : ST_COMMENT;
			ST_NAME:      ns = (c == CH_GT) ? ST_EMIT : ST_TAG;
			default:      ns = ST_TEXT;
		endcase
		return ns;
	endfunction

endpackage

### rtl/markup_tokenizer.sv
// ----------------------------------------------------------------------------
// Markup tokenizer
// Byte-serial lexer for an HTML-like document that tags text, tag and comment
// bytes with their token kind and signals the ends of text, tags and comments.
// ----------------------------------------------------------------------------
// Usage:
// The char channel takes one document byte per word, with doc_end set on the
// final byte of a document. The token channel delivers one result word per
// cycle while not stalled: a text, tag or comment byte with its blank flag,
// or an end event. run_last marks the final word caused by one input byte.
// A byte that adds nothing and ends nothing produces no word at all.
// A byte accepted into the input register is decoded there and its words
// are loaded into the result group register, from which the first word is
// on the token channel; a full group holds the byte in the input register.
// Throughput: one byte per cycle while each byte yields at most one word and
// the receiver does not stall. A byte that closes tokens yields up to three
// words; the result group register drains them one per cycle and the char
// channel stalls for all but the last of those cycles.
// Reset clears the lexer to the text state with no pending tokens and empties
// both the input register and the result group. When the token receiver
// stalls, the current word holds and the char channel stalls as soon as the
// input register is occupied.
// ----------------------------------------------------------------------------
module markup_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_byte,
	input  logic       doc_end,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [2:0] kind,
	output logic [7:0] out_byte,
	output logic       is_blank,
	output logic       run_last
);
	import mtok_pkg::*;

	// Input register: the byte under decode and its end-of-document mark.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	// Lexer state, updated only when the decoded byte moves into the group.
	lex_state_t lex_q;
	logic       closing_q;
	logic       text_q;
	logic       tag_q;
	logic       comm_q;

	// Result group: all words caused by one byte, sent out one by one.
	tok_res_t [MAX_RES-1:0] grp_q;
	logic [RES_CNT_W-1:0]   grp_n_q;
	logic [RES_IDX_W-1:0]   grp_ptr_q;

	// Decode of the byte in the input register.
	lex_state_t ns_raw;
	logic       blank_c;
	logic       closing_upd;
	logic       emit_tag;
	logic       emit_comm;
	logic       emit_text;
	logic       text_upd;
	logic       tag_upd;
	logic       comm_upd;
	logic       flush_gt;
	logic       flush_any;

	// Next state.
	lex_state_t lex_n;
	logic       closing_n;
	logic       text_n;
	logic       tag_n;
	logic       comm_n;

	// New result group.
	tok_res_t [MAX_RES-1:0] res;
	logic [RES_CNT_W-1:0]   res_n;

	// Handshake.
	logic out_fire;
	logic grp_done;
	logic grp_free;
	logic advance;

	assign token_valid = (grp_n_q != '0);
	assign out_fire    = token_valid && !token_stall;
	assign grp_done    = out_fire && ({1'b0, grp_ptr_q} == grp_n_q - 1'b1);
	assign grp_free    = (grp_n_q == '0) || grp_done;
	assign advance     = valid_s1 && grp_free;
	assign char_stall  = valid_s1 && !grp_free;

	assign kind     = grp_q[grp_ptr_q].kind;
	assign out_byte = grp_q[grp_ptr_q].data;
	assign is_blank = grp_q[grp_ptr_q].blank;
	assign run_last = grp_q[grp_ptr_q].last;

	// Decode: transition, close flag and which bytes join which token.
	always_comb begin
		ns_raw  = next_lex(lex_q, char_s1);
		blank_c = is_blank_byte(char_s1);

		// A close tag is marked after '</', an open tag after '<!' or a
		// plain tag name; the mark is otherwise kept from tag to tag.
		closing_upd = closing_q;
		if (lex_q == ST_SLASH)
			closing_upd = 1'b1;
		if (lex_q == ST_NAME)
			closing_upd = 1'b0;
		if ((lex_q == ST_LT) && (char_s1 == CH_BANG))
			closing_upd = 1'b0;

		emit_tag  = (ns_raw == ST_TAG) || (ns_raw == ST_NAME);
		// Only a byte read while already in the comment body belongs to it.
		emit_comm = (lex_q == ST_COMMENT) && (ns_raw == ST_COMMENT);
		emit_text = (lex_q == ST_TEXT) && (ns_raw == ST_TEXT);

		text_upd = text_q || (emit_text && !blank_c);
		tag_upd  = tag_q || (emit_tag && !blank_c);
		comm_upd = comm_q || (emit_comm && !blank_c);

		flush_gt  = (ns_raw == ST_EMIT);
		flush_any = flush_gt || end_s1;
	end

	// Next-state logic.
	always_comb begin
		lex_n     = ns_raw;
		closing_n = closing_upd;
		text_n    = text_upd;
		tag_n     = tag_upd;
		comm_n    = comm_upd;
		if (end_s1) begin
			lex_n     = ST_TEXT;
			closing_n = 1'b0;
			text_n    = 1'b0;
			tag_n     = 1'b0;
			comm_n    = 1'b0;
		end else if (flush_gt) begin
			lex_n  = ST_TEXT;
			text_n = 1'b0;
			tag_n  = 1'b0;
			comm_n = 1'b0;
		end
	end

	// Output logic: pack the byte word and end words in order.
	always_comb begin
		res   = '0;
		res_n = '0;
		if (emit_tag || emit_comm || emit_text) begin
			priority if (emit_tag)
				res[res_n[RES_IDX_W-1:0]].kind = KIND_TAG_BYTE;
			else if (emit_comm)
				res[res_n[RES_IDX_W-1:0]].kind = KIND_COMMENT_BYTE;
			else
				res[res_n[RES_IDX_W-1:0]].kind = KIND_TEXT_BYTE;
			res[res_n[RES_IDX_W-1:0]].data  = char_s1;
			res[res_n[RES_IDX_W-1:0]].blank = blank_c;
			res_n = res_n + 1'b1;
		end
		if (flush_any && text_upd) begin
			res[res_n[RES_IDX_W-1:0]].kind = KIND_TEXT_END;
			res_n = res_n + 1'b1;
		end
		if (flush_any && comm_upd) begin
			res[res_n[RES_IDX_W-1:0]].kind = KIND_COMMENT_END;
			res_n = res_n + 1'b1;
		end
		if (flush_any && tag_upd) begin
			res[res_n[RES_IDX_W-1:0]].kind = closing_upd ? KIND_CLOSE_END : KIND_OPEN_END;
			res_n = res_n + 1'b1;
		end
		if (res_n != '0)
			res[res_n[RES_IDX_W-1:0] - 1'b1].last = 1'b1;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= char_byte;
			end_s1  <= doc_end;
		end
	end

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q     <= ST_TEXT;
			closing_q <= 1'b0;
			text_q    <= 1'b0;
			tag_q     <= 1'b0;
			comm_q    <= 1'b0;
		end else if (advance) begin
			lex_q     <= lex_n;
			closing_q <= closing_n;
			text_q    <= text_n;
			tag_q     <= tag_n;
			comm_q    <= comm_n;
		end
	end

	// Result group control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_n_q   <= '0;
			grp_ptr_q <= '0;
		end else if (advance) begin
			grp_n_q   <= res_n;
			grp_ptr_q <= '0;
		end else if (grp_done) begin
			grp_n_q   <= '0;
			grp_ptr_q <= '0;
		end else if (out_fire) begin
			grp_ptr_q <= grp_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			grp_q <= res;
	end

`ifndef SYNTH
	// The read pointer stays inside the group being sent.
	a_ptr_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ({1'b0, grp_ptr_q} < grp_n_q))
		else $error("result pointer outside of group");

	// run_last appears exactly on the final word of a group.
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (run_last == ({1'b0, grp_ptr_q} == grp_n_q - 1'b1)))
		else $error("run_last not on final word of group");

	// After the final byte of a document the lexer is back at reset state.
	a_doc_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && end_s1) |=> ((lex_q == ST_TEXT) && !closing_q && !text_q
			&& !tag_q && !comm_q))
		else $error("lexer not reset after document end");

	// A new byte never enters while the current group still has words left.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_stall) |-> !advance)
		else $error("group overwritten while stalled");
`endif

endmodule

### tb/markup_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// Markup tokenizer testbench
// Streams directed and randomly built documents into the char channel and
// checks every token word against a behavioral lexer kept in a scoreboard.
// The sender idles and the token receiver stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module markup_tokenizer_tb;

	import mtok_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 400;
	// Cycles to keep watching the token channel once nothing is expected.
	localparam int SETTLE_CYCLES = 20;

	// Behavioral lexer and the queue of token words it expects to see.
	class token_checker;
		tok_res_t   expected_words[$];
		tok_res_t   group[$];
		lex_state_t state;
		bit         closing;
		bit         text_open;
		bit         tag_open;
		bit         comment_open;
		int         errors;
		int         words_checked;

		function new();
			reset_lexer();
			errors = 0;
			words_checked = 0;
		endfunction

		function void reset_lexer();
			state = ST_TEXT;
			closing = 1'b0;
			text_open = 1'b0;
			tag_open = 1'b0;
			comment_open = 1'b0;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		function void add_word(logic [2:0] k, logic [7:0] b, logic bl);
			tok_res_t w;
			w.kind = k;
			w.data = b;
			w.blank = bl;
			w.last = 1'b0;
			group.push_back(w);
		endfunction

		// Ends come in a fixed order: text, then comment, then tag.
		function void flush_ends();
			if (text_open)
				add_word(KIND_TEXT_END, 8'h00, 1'b0);
			if (comment_open)
				add_word(KIND_COMMENT_END, 8'h00, 1'b0);
			if (tag_open)
				add_word(closing ? KIND_CLOSE_END : KIND_OPEN_END, 8'h00, 1'b0);
			text_open = 1'b0;
			comment_open = 1'b0;
			tag_open = 1'b0;
		endfunction

		// Runs one accepted byte through the lexer and queues its words.
		function void lex_byte(logic [7:0] c, logic last);
			lex_state_t s;
			lex_state_t ns;
			logic       blank;
			group.delete();
			s = state;
			blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

			// The close flag is set or cleared here and by a document end, and survives the tag end.
			if (s == ST_SLASH)
				closing = 1'b1;
			if (s == ST_NAME)
				closing = 1'b0;
			if (s == ST_LT && c == CH_BANG)
				closing = 1'b0;

			case (s)
				ST_TEXT:      ns = (c == CH_LT) ? ST_LT : ST_TEXT;
				ST_LT:        ns = (c == CH_BANG) ? ST_BANG :
					((c == CH_SLASH) ? ST_SLASH : ST_NAME);
				ST_TAG:       ns = (c == CH_GT) ? ST_EMIT : ST_TAG;
				ST_SLASH:     ns = ST_TAG;
				ST_BANG:      ns = (c == CH_DASH) ? ST_BANG_DASH : ST_TAG;
				ST_DASH1:     ns = (c == CH_DASH) ? ST_DASH2 : ST_COMMENT;
				ST_DASH2:     ns = (c == CH_GT) ? ST_EMIT : ST_COMMENT;
				ST_BANG_DASH: ns = (c == CH_DASH) ? ST_COMMENT : ST_TAG;
				ST_COMMENT:   ns = (c == CH_DASH) ? ST_DASH1 : ST_COMMENT;
				ST_NAME:      ns = (c == CH_GT) ? ST_EMIT : ST_TAG;
				default:      ns = ST_TEXT;
			endcase

			if (ns == ST_TAG || ns == ST_NAME) begin
				add_word(KIND_TAG_BYTE, c, blank);
				if (!blank)
					tag_open = 1'b1;
			end
			// A byte re-entering the body after dashes is not comment text.
			if (ns == ST_COMMENT && s == ST_COMMENT) begin
				add_word(KIND_COMMENT_BYTE, c, blank);
				if (!blank)
					comment_open = 1'b1;
			end
			if (ns == ST_TEXT && s == ST_TEXT) begin
				add_word(KIND_TEXT_BYTE, c, blank);
				if (!blank)
					text_open = 1'b1;
			end
			if (ns == ST_EMIT) begin
				flush_ends();
				ns = ST_TEXT;
			end
			state = ns;

			if (last) begin
				flush_ends();
				reset_lexer();
			end

			if (group.size() != 0)
				group[group.size() - 1].last = 1'b1;
			foreach (group[i])
				expected_words.push_back(group[i]);
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] token word %0d: %s", $realtime, words_checked, msg);
			errors++;
		endtask

		task check_word(logic [2:0] k, logic [7:0] b, logic bl, logic rl);
			tok_res_t want;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d byte %02h", k, b));
			end else begin
				want = expected_words.pop_front();
				if (k !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", k, want.kind));
				if (b !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h", b, want.data));
				if (bl !== want.blank)
					report_mismatch($sformatf("is_blank %0b, expected %0b", bl, want.blank));
				if (rl !== want.last)
					report_mismatch($sformatf("run_last %0b, expected %0b", rl, want.last));
			end
			words_checked++;
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	logic [7:0] char_byte;
	logic       doc_end;
	logic       token_valid;
	logic       token_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic       is_blank;
	logic       run_last;

	token_checker chk;
	int           items_sent;
	bit           tx_calm;
	logic [7:0]   doc_bytes[$];

	// Token stall pattern: free runs alternate with stall bursts.
	bit           stall_phase = 1'b0;
	int unsigned  stall_run = 0;

	markup_tokenizer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_byte   (char_byte),
		.doc_end     (doc_end),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.kind        (kind),
		.out_byte    (out_byte),
		.is_blank    (is_blank),
		.run_last    (run_last)
	);

	always #HALF_PERIOD clk = ~clk;

	// The receiver alternates stall bursts and free runs, each drawn from a short
	// range or, about one time in ten, from a long one.
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run--;
		end else if (stall_phase) begin
			stall_phase = 1'b0;
			stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 12);
		end else begin
			stall_phase = 1'b1;
			stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end
		token_stall <= stall_phase;
	end

	// Token channel monitor. Outputs are sampled at the edge, before any
	// update scheduled at that edge lands.
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall)
			chk.check_word(kind, out_byte, is_blank, run_last);
	end

	// Sender idle length: mostly none, often short, rarely long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Presents one byte and waits for the handshake. When drain is set the
	// sender first holds off until every expected word has come out.
	task automatic send_char(input logic [7:0] c, input logic last, input bit drain);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0 || drain) begin
			char_valid <= 1'b0;
			char_byte <= 8'($urandom_range(0, 255));
			doc_end <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
			if (drain) begin
				@(posedge clk);
				while (chk.outstanding() != 0)
					@(posedge clk);
			end
		end
		char_valid <= 1'b1;
		char_byte <= c;
		doc_end <= last;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		chk.lex_byte(c, last);
		items_sent++;
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] letter_char();
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic logic [7:0] text_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return blank_char();
		if (r < 35)
			return 8'($urandom_range(0, 255));
		return letter_char();
	endfunction

	function automatic logic [7:0] name_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return blank_char();
		if (r < 18)
			return 8'($urandom_range(0, 255));
		return letter_char();
	endfunction

	// Comment bodies get plenty of dashes so that the lone '-' and '--'
	// states are visited and left again without a closing '>'.
	function automatic logic [7:0] comment_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return CH_DASH;
		if (r < 30)
			return blank_char();
		if (r < 40)
			return 8'($urandom_range(0, 255));
		return letter_char();
	endfunction

	function automatic logic [7:0] markup_char();
		case ($urandom_range(0, 5))
			0:       return CH_LT;
			1:       return CH_SLASH;
			2:       return CH_BANG;
			3:       return CH_DASH;
			4:       return CH_GT;
			default: return blank_char();
		endcase
	endfunction

	// Builds a document from well-formed pieces with random content, mixed
	// with raw noise and broken markup.
	function automatic void build_document();
		int pieces;
		doc_bytes.delete();
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat ($urandom_range(1, 8))
						doc_bytes.push_back(text_char());
				end
				3, 4: begin
					doc_bytes.push_back(CH_LT);
					repeat ($urandom_range(1, 6))
						doc_bytes.push_back(name_char());
					doc_bytes.push_back(CH_GT);
				end
				5: begin
					doc_bytes.push_back(CH_LT);
					doc_bytes.push_back(CH_SLASH);
					repeat ($urandom_range(1, 6))
						doc_bytes.push_back(name_char());
					doc_bytes.push_back(CH_GT);
				end
				6: begin
					doc_bytes.push_back(CH_LT);
					doc_bytes.push_back(CH_BANG);
					doc_bytes.push_back(CH_DASH);
					doc_bytes.push_back(CH_DASH);
					repeat ($urandom_range(0, 8))
						doc_bytes.push_back(comment_char());
					doc_bytes.push_back(CH_DASH);
					doc_bytes.push_back(CH_DASH);
					doc_bytes.push_back(CH_GT);
				end
				7: begin
					doc_bytes.push_back(CH_LT);
					doc_bytes.push_back(CH_BANG);
					repeat ($urandom_range(1, 6))
						doc_bytes.push_back(name_char());
					doc_bytes.push_back(CH_GT);
				end
				8: begin
					repeat ($urandom_range(1, 6))
						doc_bytes.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					doc_bytes.push_back(CH_LT);
					repeat ($urandom_range(1, 4))
						doc_bytes.push_back(markup_char());
				end
			endcase
		end
	endfunction

	// Sends the document built last. Most documents end with doc_end on the
	// final byte; some are cut short mid-token, and a few carry no doc_end
	// at all so the lexer state runs on into the next one.
	task automatic send_document(input bit drain_first);
		int stop;
		bit with_end;
		with_end = ($urandom_range(0, 9) != 0);
		stop = doc_bytes.size();
		if ($urandom_range(0, 4) == 0)
			stop = $urandom_range(1, doc_bytes.size());
		for (int i = 0; i < stop; i++)
			send_char(doc_bytes[i], with_end && (i == stop - 1), drain_first && (i == 0));
	endtask

	initial begin
		string dir_text;
		// Every input starts at a known value; reset is held from time zero.
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_byte = 8'h00;
		doc_end = 1'b0;
		chk = new();
		items_sent = 0;
		tx_calm = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: extreme byte values as text, a close tag, a comment
		// with a lone dash inside, a declaration that turns into an open tag,
		// tab, CR and LF as blank text, a tag cut off by doc_end (a tag byte,
		// then an open tag end), and finally a '<' with doc_end that yields
		// nothing.
		send_char(8'h00, 1'b0, 1'b0);
		send_char(8'hFF, 1'b0, 1'b0);
		dir_text = "</p><!--x-y--><!d>\t\r\n<q";
		for (int k = 0; k < dir_text.len(); k++)
			send_char(dir_text[k], k == dir_text.len() - 1, 1'b0);
		send_char(CH_LT, 1'b1, 1'b0);

		// Random documents. The first one waits for the directed words to
		// drain completely; later ones do so now and then.
		build_document();
		send_document(1'b1);
		while (items_sent < RANDOM_ITEMS + 26) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			build_document();
			send_document($urandom_range(0, 7) == 0);
		end
		char_valid <= 1'b0;

		while (chk.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (chk.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
